// ===== hdl/ola_pkg.sv =====
// Shared constants, opcodes, status codes and sequencer states of the ordered array list.
package ola_pkg;

    localparam int DEPTH     = 32;
    localparam int WORD_BITS = 32;

    localparam int OP_W   = 3;
    localparam int POS_W  = 6;
    localparam int VAL_W  = 32;
    localparam int STAT_W = 3;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR  = 3'd0,
        OP_INSERT = 3'd1,
        OP_DELETE = 3'd2,
        OP_READ   = 3'd3,
        OP_LOCATE = 3'd4,
        OP_PRED   = 3'd5,
        OP_SUCC   = 3'd6
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK       = 3'd0,
        STAT_BADPOS   = 3'd1,
        STAT_FULL     = 3'd2,
        STAT_NOTFOUND = 3'd3,
        STAT_NONEIGH  = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SHIFT_UP,
        ST_INS_WRITE,
        ST_SHIFT_DN,
        ST_READ,
        ST_SCAN,
        ST_SUCC
    } t_state;

endpackage

// ===== hdl/ordered_array_list.sv =====
// Top level of the ordered array list: request sequencer around one entry RAM.
//
//  channel  | handshake            | words
//  ---------+----------------------+---------------------------------------------------
//  request  | start, busy          | i_op, i_position, i_value
//  result   | o_strobe (one cycle) | o_status, o_value_out, o_found_position,
//           |                      | o_length, o_empty_res
//
// Clear, errors and insert at the tail finish from idle; read makes one RAM read.
// Insert before p shifts entries from p up, then writes; delete shifts the tail down.
// Locate, predecessor, successor scan from the first entry, one RAM read per cycle.
// Every shift or scan step is one pass through the single RAM read port.
// Reset (synchronous, active low) empties the list; the result has no back-pressure.
module ordered_array_list (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [ola_pkg::OP_W-1:0]   i_op,
    input  logic [ola_pkg::POS_W-1:0]  i_position,
    input  logic [ola_pkg::VAL_W-1:0]  i_value,
    output logic                       o_strobe,
    output logic [ola_pkg::STAT_W-1:0] o_status,
    output logic [ola_pkg::VAL_W-1:0]  o_value_out,
    output logic [ola_pkg::POS_W-1:0]  o_found_position,
    output logic [ola_pkg::POS_W-1:0]  o_length,
    output logic                       o_empty_res
);

    import ola_pkg::*;

    t_state               r_state, n_state;
    t_op                  r_op, n_op;
    logic [IDX_W-1:0]     r_idx, n_idx;
    logic [WORD_BITS-1:0] r_value, n_value;
    logic [CNT_W-1:0]     r_count, n_count;
    logic [IDX_W-1:0]     r_addr, n_addr;
    logic                 r_issue, n_issue;
    logic                 r_pend, n_pend;
    logic [IDX_W-1:0]     r_daddr, n_daddr;
    logic [WORD_BITS-1:0] r_prev, n_prev;
    logic                 r_valid, n_valid;
    t_status              r_status, n_status;
    logic [WORD_BITS-1:0] r_vout, n_vout;
    logic [CNT_W-1:0]     r_fpos, n_fpos;

    logic                 w_accept;
    t_op                  w_op;
    logic [CMP_W-1:0]     w_pos;
    logic [CMP_W-1:0]     w_cnt;
    logic                 w_ins_bad;
    logic                 w_rd_bad;
    logic                 w_full;
    logic                 w_append;
    logic [IDX_W-1:0]     w_in_idx;
    logic [IDX_W-1:0]     w_last;
    logic                 w_dlast;
    logic                 w_hit;

    logic                 w_we;
    logic [IDX_W-1:0]     w_waddr;
    logic [WORD_BITS-1:0] w_wdata;
    logic [WORD_BITS-1:0] w_rdata;

    ola_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_addr),
        .o_rdata (w_rdata)
    );

    assign busy      = (r_state != ST_IDLE);
    assign w_accept  = start && !busy;
    assign w_op      = t_op'(i_op);
    assign w_pos     = CMP_W'(i_position);
    assign w_cnt     = CMP_W'(r_count);
    assign w_ins_bad = (w_pos == '0) || (w_pos > w_cnt + CMP_W'(1));
    assign w_rd_bad  = (w_pos == '0) || (w_pos > w_cnt);
    assign w_full    = (r_count == CNT_W'(DEPTH));
    assign w_append  = (w_pos == w_cnt + CMP_W'(1));
    assign w_in_idx  = IDX_W'(i_position - POS_W'(1));
    assign w_last    = IDX_W'(r_count - CNT_W'(1));
    assign w_dlast   = (r_daddr == w_last);
    assign w_hit     = r_pend && (w_rdata == r_value);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    case (w_op)
                        OP_INSERT: begin
                            if (!w_ins_bad && !w_full && !w_append) begin
                                n_state = ST_SHIFT_UP;
                            end
                        end
                        OP_DELETE: begin
                            if (!w_rd_bad) begin
                                n_state = ST_SHIFT_DN;
                            end
                        end
                        OP_READ: begin
                            if (!w_rd_bad) begin
                                n_state = ST_READ;
                            end
                        end
                        OP_LOCATE, OP_PRED, OP_SUCC: begin
                            if (r_count != '0) begin
                                n_state = ST_SCAN;
                            end
                        end
                        default: n_state = ST_IDLE;
                    endcase
                end
            end
            ST_SHIFT_UP: begin
                if (r_pend && (r_daddr == r_idx)) begin
                    n_state = ST_INS_WRITE;
                end
            end
            ST_INS_WRITE: n_state = ST_IDLE;
            ST_SHIFT_DN: begin
                if (r_pend && w_dlast) begin
                    n_state = ST_IDLE;
                end
            end
            ST_READ: begin
                if (r_pend) begin
                    n_state = ST_IDLE;
                end
            end
            ST_SCAN: begin
                if (w_hit) begin
                    n_state = (r_op == OP_SUCC && !w_dlast) ? ST_SUCC : ST_IDLE;
                end else if (r_pend && w_dlast) begin
                    n_state = ST_IDLE;
                end
            end
            ST_SUCC: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_op     = r_op;
        n_idx    = r_idx;
        n_value  = r_value;
        n_count  = r_count;
        n_addr   = r_addr;
        n_issue  = r_issue;
        n_pend   = r_issue;
        n_daddr  = r_addr;
        n_prev   = r_prev;
        n_valid  = 1'b0;
        n_status = r_status;
        n_vout   = r_vout;
        n_fpos   = r_fpos;
        w_we     = 1'b0;
        w_waddr  = r_daddr;
        w_wdata  = w_rdata;

        unique case (r_state)
            ST_IDLE: begin
                n_issue = 1'b0;
                if (w_accept) begin
                    n_op     = w_op;
                    n_idx    = w_in_idx;
                    n_value  = i_value[WORD_BITS-1:0];
                    n_status = STAT_OK;
                    n_vout   = '0;
                    n_fpos   = '0;
                    case (w_op)
                        OP_CLEAR: begin
                            n_count = '0;
                            n_valid = 1'b1;
                        end
                        OP_INSERT: begin
                            if (w_ins_bad) begin
                                n_status = STAT_BADPOS;
                                n_valid  = 1'b1;
                            end else if (w_full) begin
                                n_status = STAT_FULL;
                                n_valid  = 1'b1;
                            end else if (w_append) begin
                                w_we    = 1'b1;
                                w_waddr = w_in_idx;
                                w_wdata = i_value[WORD_BITS-1:0];
                                n_count = r_count + CNT_W'(1);
                                n_valid = 1'b1;
                            end else begin
                                n_addr  = w_last;
                                n_issue = 1'b1;
                            end
                        end
                        OP_DELETE, OP_READ: begin
                            if (w_rd_bad) begin
                                n_status = STAT_BADPOS;
                                n_valid  = 1'b1;
                            end else begin
                                n_addr  = w_in_idx;
                                n_issue = 1'b1;
                            end
                        end
                        OP_LOCATE, OP_PRED, OP_SUCC: begin
                            if (r_count == '0) begin
                                n_status = STAT_NOTFOUND;
                                n_valid  = 1'b1;
                            end else begin
                                n_addr  = '0;
                                n_issue = 1'b1;
                            end
                        end
                        default: n_valid = 1'b1;
                    endcase
                end
            end
            ST_SHIFT_UP: begin
                if (r_issue) begin
                    if (r_addr == r_idx) begin
                        n_issue = 1'b0;
                    end else begin
                        n_addr = r_addr - IDX_W'(1);
                    end
                end
                if (r_pend) begin
                    w_we    = 1'b1;
                    w_waddr = r_daddr + IDX_W'(1);
                end
            end
            ST_INS_WRITE: begin
                w_we    = 1'b1;
                w_waddr = r_idx;
                w_wdata = r_value;
                n_count = r_count + CNT_W'(1);
                n_valid = 1'b1;
            end
            ST_SHIFT_DN: begin
                if (r_issue) begin
                    if (r_addr == w_last) begin
                        n_issue = 1'b0;
                    end else begin
                        n_addr = r_addr + IDX_W'(1);
                    end
                end
                if (r_pend) begin
                    if (r_daddr == r_idx) begin
                        n_prev = w_rdata;
                    end else begin
                        w_we    = 1'b1;
                        w_waddr = r_daddr - IDX_W'(1);
                    end
                    if (w_dlast) begin
                        n_count = r_count - CNT_W'(1);
                        n_vout  = (r_daddr == r_idx) ? w_rdata : r_prev;
                        n_issue = 1'b0;
                        n_valid = 1'b1;
                    end
                end
            end
            ST_READ: begin
                n_issue = 1'b0;
                if (r_pend) begin
                    n_vout  = w_rdata;
                    n_valid = 1'b1;
                end
            end
            ST_SCAN: begin
                if (r_issue) begin
                    if (r_addr == w_last) begin
                        n_issue = 1'b0;
                    end else begin
                        n_addr = r_addr + IDX_W'(1);
                    end
                end
                if (r_pend) begin
                    n_prev = w_rdata;
                end
                if (w_hit) begin
                    n_issue = 1'b0;
                    case (r_op)
                        OP_LOCATE: begin
                            n_fpos  = CNT_W'(r_daddr) + CNT_W'(1);
                            n_valid = 1'b1;
                        end
                        OP_PRED: begin
                            if (r_daddr == '0) begin
                                n_status = STAT_NONEIGH;
                            end else begin
                                n_vout = r_prev;
                            end
                            n_valid = 1'b1;
                        end
                        default: begin
                            if (w_dlast) begin
                                n_status = STAT_NONEIGH;
                                n_valid  = 1'b1;
                            end
                        end
                    endcase
                end else if (r_pend && w_dlast) begin
                    n_status = STAT_NOTFOUND;
                    n_issue  = 1'b0;
                    n_valid  = 1'b1;
                end
            end
            ST_SUCC: begin
                n_issue = 1'b0;
                n_vout  = w_rdata;
                n_valid = 1'b1;
            end
            default: n_issue = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_issue <= 1'b0;
            r_pend  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_issue <= n_issue;
            r_pend  <= n_pend;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_idx    <= n_idx;
        r_value  <= n_value;
        r_addr   <= n_addr;
        r_daddr  <= n_daddr;
        r_prev   <= n_prev;
        r_status <= n_status;
        r_vout   <= n_vout;
        r_fpos   <= n_fpos;
    end

    assign o_strobe         = r_valid;
    assign o_status         = r_status;
    assign o_value_out      = VAL_W'(r_vout);
    assign o_found_position = POS_W'(r_fpos);
    assign o_length         = POS_W'(r_count);
    assign o_empty_res      = (r_count == '0);

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("entry count exceeds depth");

    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("result strobe while sequencer busy");

    a_clear_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_op == OP_CLEAR) |=> (o_strobe && o_length == '0))
        else $error("clear did not empty the list");

    a_shift_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SHIFT_UP && r_pend) |-> (r_daddr >= r_idx))
        else $error("insert shift ran below the insert point");

endmodule

// ===== hdl/ola_ram.sv =====
// Generic simple dual-port RAM with one write port and one registered read port.
module ola_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
